FILE: hdl/compact_scalar_value_encoder_macros.svh
// assertion helpers shared by the encoder blocks
`ifndef COMPACT_SCALAR_VALUE_ENCODER_MACROS_SVH
`define COMPACT_SCALAR_VALUE_ENCODER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CSVE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csve check failed");

// next-cycle implication, sampled on clk, off during reset
`define CSVE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csve check failed");

`endif

FILE: hdl/csve_pkg.sv
package csve_pkg;

    typedef enum logic [2:0] {
        CMD_NULL  = 3'd0,
        CMD_BOOL  = 3'd1,
        CMD_INT32 = 3'd2,
        CMD_INT64 = 3'd3,
        CMD_DATE  = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [63:0] value;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } result_t;

    // tag byte plus left-aligned payload bytes still to send after it
    typedef struct packed {
        logic [7:0]  tag;
        logic [3:0]  nrem;
        logic [63:0] data;
    } enc_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] TAG_NULL     = 8'h4e;
    localparam logic [7:0] TAG_TRUE     = 8'h54;
    localparam logic [7:0] TAG_FALSE    = 8'h46;
    localparam logic [7:0] TAG_INT_1B   = 8'h90;
    localparam logic [7:0] TAG_INT_2B   = 8'hc8;
    localparam logic [7:0] TAG_INT_3B   = 8'hd4;
    localparam logic [7:0] TAG_INT      = 8'h49;
    localparam logic [7:0] TAG_LONG_1B  = 8'he0;
    localparam logic [7:0] TAG_LONG_2B  = 8'hf8;
    localparam logic [7:0] TAG_LONG_3B  = 8'h3c;
    localparam logic [7:0] TAG_LONG_4B  = 8'h59;
    localparam logic [7:0] TAG_LONG     = 8'h4c;
    localparam logic [7:0] TAG_DATE_MIN = 8'h4b;
    localparam logic [7:0] TAG_DATE_MS  = 8'h4a;

    // 60000 = 2^5 * 1875, the odd part is divided out by its inverse mod 2^32
    localparam int MS_PER_MINUTE  = 60000;
    localparam int MINUTE_SHIFT   = 5;
    localparam int MINUTE_ODD_INT = MS_PER_MINUTE >> MINUTE_SHIFT;
    localparam logic signed [11:0] MINUTE_ODD = 12'(MINUTE_ODD_INT);

    // newton iteration, each round doubles the number of correct low bits
    function automatic logic [31:0] odd_inverse(input logic [31:0] d);
        logic [31:0] y;
        y = d;
        for (int i = 0; i < 5; i++)
        begin
            y = y * (32'd2 - d * y);
        end
        return y;
    endfunction

    localparam logic [31:0] INV_MINUTE_ODD = odd_inverse(32'(MINUTE_ODD_INT));

endpackage

FILE: hdl/compact_scalar_value_encoder.sv
// path: stage one, then the queue, then the serializer, which registers each output byte
// throughput: one output byte per cycle while result_ready is high; an item is a tag plus
//   0/1/2/4/8 payload bytes, and the single-byte result port is what bounds it
// a 2-entry queue lets the classifier take new items while the serializer drains
// reset: rst_n clears all valid flags and queue pointers at once, no clearing pass
module compact_scalar_value_encoder
    import csve_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  logic    item_valid,
    output logic    item_ready,
    output result_t result,
    output logic    result_valid,
    input  logic    result_ready
);

    logic push;
    enc_t push_entry;
    logic q_full;
    logic q_empty;
    logic pop;
    enc_t head;

    csve_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    csve_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty)
    );

    csve_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

FILE: hdl/csve_front.sv
`include "compact_scalar_value_encoder_macros.svh"

module csve_front
    import csve_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  item_t item,
    input  logic  item_valid,
    output logic  item_ready,
    output logic  push,
    output enc_t  push_entry,
    input  logic  q_full
);

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [2:0]         s1_cmd_reg;
    logic [63:0]        s1_val_reg;
    logic [31:0]        s1_minutes_reg;
    logic [31:0]        s1_minutes_next;

    logic signed [31:0] v32;
    logic signed [63:0] v64;
    logic signed [43:0] minutes_back;
    logic               date_min_ok;
    logic               cmd_known;
    cmd_t               cmd;

    assign item_ready = !s1_valid_reg || !q_full;

    // low word of the minute count, exact whenever the date is whole minutes
    assign s1_minutes_next = item.value[MINUTE_SHIFT+31:MINUTE_SHIFT] * INV_MINUTE_ODD;

    always_comb
    begin
        s1_valid_next = item_ready ? item_valid : s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            s1_cmd_reg     <= item.command;
            s1_val_reg     <= item.value;
            s1_minutes_reg <= s1_minutes_next;
        end
    end

    always_comb
    begin
        v32          = s1_val_reg[31:0];
        v64          = s1_val_reg;
        cmd          = cmd_t'(s1_cmd_reg);
        // multiplying back proves both divisibility and the 32-bit range
        minutes_back = $signed(s1_minutes_reg) * MINUTE_ODD;
        date_min_ok  = (s1_val_reg[MINUTE_SHIFT-1:0] == '0) &&
                       (s1_val_reg[63:MINUTE_SHIFT] == (64-MINUTE_SHIFT)'(minutes_back));
        cmd_known    = 1'b1;
        push_entry   = '0;
        case (cmd)
            CMD_NULL:
            begin
                push_entry.tag = TAG_NULL;
            end
            CMD_BOOL:
            begin
                push_entry.tag = s1_val_reg[0] ? TAG_TRUE : TAG_FALSE;
            end
            CMD_INT32:
            begin
                if (v32 >= -32'sd16 && v32 <= 32'sd47)
                begin
                    push_entry.tag = TAG_INT_1B + v32[7:0];
                end
                else if (v32 >= -32'sd2048 && v32 <= 32'sd2047)
                begin
                    push_entry.tag  = TAG_INT_2B + v32[15:8];
                    push_entry.nrem = 4'd1;
                    push_entry.data = {v32[7:0], 56'h0};
                end
                else if (v32 >= -32'sd262144 && v32 <= 32'sd262143)
                begin
                    push_entry.tag  = TAG_INT_3B + v32[23:16];
                    push_entry.nrem = 4'd2;
                    push_entry.data = {v32[15:0], 48'h0};
                end
                else
                begin
                    push_entry.tag  = TAG_INT;
                    push_entry.nrem = 4'd4;
                    push_entry.data = {v32, 32'h0};
                end
            end
            CMD_INT64:
            begin
                if (v64 >= -64'sd8 && v64 <= 64'sd15)
                begin
                    push_entry.tag = TAG_LONG_1B + v64[7:0];
                end
                else if (v64 >= -64'sd2048 && v64 <= 64'sd2047)
                begin
                    push_entry.tag  = TAG_LONG_2B + v64[15:8];
                    push_entry.nrem = 4'd1;
                    push_entry.data = {v64[7:0], 56'h0};
                end
                else if (v64 >= -64'sd262144 && v64 <= 64'sd262143)
                begin
                    push_entry.tag  = TAG_LONG_3B + v64[23:16];
                    push_entry.nrem = 4'd2;
                    push_entry.data = {v64[15:0], 48'h0};
                end
                else if (v64 >= -64'sd2147483648 && v64 <= 64'sd2147483647)
                begin
                    push_entry.tag  = TAG_LONG_4B;
                    push_entry.nrem = 4'd4;
                    push_entry.data = {v64[31:0], 32'h0};
                end
                else
                begin
                    push_entry.tag  = TAG_LONG;
                    push_entry.nrem = 4'd8;
                    push_entry.data = v64;
                end
            end
            CMD_DATE:
            begin
                if (date_min_ok)
                begin
                    push_entry.tag  = TAG_DATE_MIN;
                    push_entry.nrem = 4'd4;
                    push_entry.data = {s1_minutes_reg, 32'h0};
                end
                else
                begin
                    push_entry.tag  = TAG_DATE_MS;
                    push_entry.nrem = 4'd8;
                    push_entry.data = v64;
                end
            end
            default:
            begin
                cmd_known = 1'b0;
            end
        endcase
    end

    // unknown commands leave stage one without a queue entry
    assign push = s1_valid_reg && cmd_known && !q_full;

    `CSVE_ASSERT_NXT(a_s1_holds_on_stall, s1_valid_reg && q_full,
                     s1_valid_reg && $stable(s1_val_reg) && $stable(s1_cmd_reg))

endmodule

FILE: hdl/csve_queue.sv
`include "compact_scalar_value_encoder_macros.svh"

module csve_queue
    import csve_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  enc_t push_entry,
    output logic full,
    input  logic pop,
    output enc_t head,
    output logic empty
);

    enc_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `CSVE_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `CSVE_ASSERT_IMP(a_pop_not_empty, pop, !empty)

endmodule

FILE: hdl/csve_back.sv
`include "compact_scalar_value_encoder_macros.svh"

module csve_back
    import csve_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  enc_t    head,
    input  logic    q_empty,
    output logic    pop,
    output result_t result,
    output logic    result_valid,
    input  logic    result_ready
);

    logic        cur_valid_reg;
    logic        cur_valid_next;
    logic [71:0] sh_reg;
    logic [71:0] sh_next;
    logic [3:0]  rem_reg;
    logic [3:0]  rem_next;
    logic        res_valid_reg;
    logic        res_valid_next;
    result_t     res_reg;
    logic        emit;
    logic        finishing;

    // a beat moves into the output register whenever it is free or draining
    assign emit      = cur_valid_reg && (!res_valid_reg || result_ready);
    assign finishing = emit && (rem_reg == '0);
    assign pop       = !q_empty && (!cur_valid_reg || finishing);

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        sh_next        = sh_reg;
        rem_next       = rem_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            sh_next        = {head.tag, head.data};
            rem_next       = head.nrem;
        end
        else if (finishing)
        begin
            cur_valid_next = 1'b0;
        end
        else if (emit)
        begin
            sh_next  = {sh_reg[63:0], 8'h00};
            rem_next = rem_reg - 4'd1;
        end
        res_valid_next = emit ? 1'b1 : (result_ready ? 1'b0 : res_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        if (emit)
        begin
            res_reg.out_byte <= sh_reg[71:64];
            res_reg.last     <= (rem_reg == '0);
        end
    end

    assign result       = res_reg;
    assign result_valid = res_valid_reg;

    `CSVE_ASSERT_NXT(a_rem_countdown, emit && rem_reg != '0,
                     cur_valid_reg && rem_reg == $past(rem_reg) - 4'd1)
    `CSVE_ASSERT_NXT(a_reload_on_finish, finishing && !q_empty, cur_valid_reg)

endmodule

FILE: tb/compact_scalar_value_encoder_tb.sv
`timescale 1ns / 1ps

module compact_scalar_value_encoder_tb
    import csve_pkg::*;
();

    // command codes the block must swallow without output
    localparam logic [2:0] CMD_RESERVED_LO = 3'd5;
    localparam logic [2:0] CMD_RESERVED_HI = 3'd7;

    localparam int ITEMS_PER_PHASE = 100;
    localparam int SETTLE_CYCLES   = 16;

    logic    clk;
    logic    rst_n        = 1'b0;
    item_t   item         = '0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    result_t result;
    logic    result_valid;
    logic    result_ready = 1'b0;

    result_t expected_bytes[$];
    int      mismatches     = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;

    compact_scalar_value_encoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------
    // expected byte stream
    // ---------------------------------------------------------------

    // tag first, then the low nbytes of payload, most significant first
    function automatic void queue_encoding(input logic [7:0] tag, input logic [63:0] payload,
                                           input int nbytes);
        result_t r;
        int      k;
        r.out_byte = tag;
        r.last     = (nbytes == 0);
        expected_bytes.insert(expected_bytes.size(), r);
        for (k = nbytes - 1; k >= 0; k--)
        begin
            r.out_byte = payload[8*k +: 8];
            r.last     = (k == 0);
            expected_bytes.insert(expected_bytes.size(), r);
        end
    endfunction

    function automatic void predict_encoding(input item_t it);
        logic [63:0] u;
        longint      s;
        longint      mins;
        u = it.value;
        case (it.command)
            CMD_NULL:
                queue_encoding(TAG_NULL, '0, 0);
            CMD_BOOL:
                queue_encoding(u[0] ? TAG_TRUE : TAG_FALSE, '0, 0);
            CMD_INT32:
            begin
                s = longint'($signed(u[31:0]));
                if (s >= -16 && s <= 47)
                    queue_encoding(8'(TAG_INT_1B + u[7:0]), '0, 0);
                else if (s >= -2048 && s <= 2047)
                    queue_encoding(8'(TAG_INT_2B + u[15:8]), u, 1);
                else if (s >= -262144 && s <= 262143)
                    queue_encoding(8'(TAG_INT_3B + u[23:16]), u, 2);
                else
                    queue_encoding(TAG_INT, u, 4);
            end
            CMD_INT64:
            begin
                s = $signed(u);
                if (s >= -8 && s <= 15)
                    queue_encoding(8'(TAG_LONG_1B + u[7:0]), '0, 0);
                else if (s >= -2048 && s <= 2047)
                    queue_encoding(8'(TAG_LONG_2B + u[15:8]), u, 1);
                else if (s >= -262144 && s <= 262143)
                    queue_encoding(8'(TAG_LONG_3B + u[23:16]), u, 2);
                else if (s >= -64'sd2147483648 && s <= 64'sd2147483647)
                    queue_encoding(TAG_LONG_4B, u, 4);
                else
                    queue_encoding(TAG_LONG, u, 8);
            end
            CMD_DATE:
            begin
                s    = $signed(u);
                mins = s / MS_PER_MINUTE;
                // whole minutes that fit in 32 signed bits use the short date form
                if (s % MS_PER_MINUTE == 0 && mins >= -64'sd2147483648
                    && mins <= 64'sd2147483647)
                    queue_encoding(TAG_DATE_MIN, mins, 4);
                else
                    queue_encoding(TAG_DATE_MS, u, 8);
            end
            default:
                ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected byte %h last %b, got byte %h last %b",
                     $realtime, what, want.out_byte, want.last, got.out_byte, got.last);
    endtask

    always @(posedge clk)
    begin : check_beat
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                report_mismatch("unexpected beat", '0, result);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (result.out_byte !== want.out_byte || result.last !== want.last)
                    report_mismatch("wrong beat", want, result);
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    function automatic item_t make_item(input logic [2:0] cmd, input logic [63:0] val);
        item_t it;
        it.command = cmd;
        it.value   = val;
        return it;
    endfunction

    // valid is left high after the beat so back-to-back items need no extra edge
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        predict_encoding(it);
    endtask

    task automatic wait_for_drain();
        item_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
    endtask

    // operands biased toward the form boundaries and whole-minute dates
    function automatic logic [63:0] random_operand();
        longint      base;
        longint      mins;
        logic [63:0] v;
        case ($urandom_range(5))
            0: v = {$urandom, $urandom};
            1: v = longint'($urandom_range(120)) - 60;
            2:
            begin
                case ($urandom_range(5))
                    0: base = 8;
                    1: base = 16;
                    2: base = 48;
                    3: base = 2048;
                    4: base = 262144;
                    default: base = 64'sd2147483648;
                endcase
                if ($urandom_range(1))
                    base = -base;
                v = base + longint'($urandom_range(3)) - 2;
            end
            3:
            begin
                case ($urandom_range(3))
                    0: mins = longint'($signed($urandom));
                    1: mins = longint'($signed($urandom)) * 2;
                    2: mins = ($urandom_range(1) ? 64'sd2147483647 : -64'sd2147483648)
                              + longint'($urandom_range(3)) - 1;
                    default: mins = longint'($urandom_range(200)) - 100;
                endcase
                v = mins * MS_PER_MINUTE;
            end
            4:
            begin
                v = {$urandom, $urandom} >> $urandom_range(63);
                if ($urandom_range(1))
                    v = -v;
            end
            default:
                // int32-sized value under random upper bits
                v = {$urandom, 32'(longint'($urandom_range(600000)) - 300000)};
        endcase
        return v;
    endfunction

    function automatic logic [2:0] random_command();
        if ($urandom_range(15) == 0)
            return 3'($urandom_range(CMD_RESERVED_HI, CMD_RESERVED_LO));
        return 3'($urandom_range(CMD_DATE));
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    task automatic test_corner_values();
        send_item(make_item(CMD_NULL, '1));
        send_item(make_item(CMD_BOOL, 64'hffff_ffff_ffff_fffe));
        send_item(make_item(CMD_BOOL, 64'h8000_0000_0000_0001));
        send_item(make_item(CMD_INT32, 64'hffff_ffff_ffff_fff0));
        send_item(make_item(CMD_INT32, 64'h0000_0000_0000_0030));
        send_item(make_item(CMD_INT32, 64'h1234_5678_ffff_f7ff));
        send_item(make_item(CMD_INT32, 64'h0000_0000_0004_0000));
        send_item(make_item(CMD_INT32, 64'h0000_0000_8000_0000));
        send_item(make_item(CMD_INT32, 64'hffff_ffff_7fff_ffff));
        send_item(make_item(CMD_INT64, 64'd15));
        send_item(make_item(CMD_INT64, -64'sd9));
        send_item(make_item(CMD_INT64, -64'sd262144));
        send_item(make_item(CMD_INT64, 64'd262144));
        send_item(make_item(CMD_INT64, -64'sd2147483649));
        send_item(make_item(CMD_INT64, 64'h8000_0000_0000_0000));
        send_item(make_item(CMD_INT64, 64'h7fff_ffff_ffff_ffff));
        send_item(make_item(CMD_DATE, '0));
        send_item(make_item(CMD_DATE, -64'sd60000));
        send_item(make_item(CMD_DATE, 64'sd2147483647 * MS_PER_MINUTE));
        send_item(make_item(CMD_DATE, -64'sd2147483648 * MS_PER_MINUTE));
        send_item(make_item(CMD_DATE, 64'sd2147483648 * MS_PER_MINUTE));
        send_item(make_item(CMD_DATE, '1));
        send_item(make_item(CMD_DATE, 64'h8000_0000_0000_0000));
    endtask

    task automatic test_ignored_commands();
        int c;
        for (c = CMD_RESERVED_LO; c <= CMD_RESERVED_HI; c++)
            send_item(make_item(3'(c), {$urandom, $urandom}));
        send_item(make_item(CMD_NULL, '0));
    endtask

    task automatic test_random_stream(input int send_idle, input int recv_stall, input int n);
        item_t it;
        int    sent;
        send_idle_pct  = send_idle;
        recv_stall_pct = recv_stall;
        sent           = 0;
        while (sent < n)
        begin
            it = make_item(random_command(), random_operand());
            send_item(it);
            if (it.command <= CMD_DATE)
                sent++;
        end
    endtask

    // long encodings piled up, then the sender holds off until all bytes are out
    task automatic test_pause_until_drained();
        int k;
        send_idle_pct  = 0;
        recv_stall_pct = 50;
        for (k = 0; k < 8; k++)
            send_item(make_item(CMD_INT64, {1'b1, 31'($urandom), $urandom}));
        wait_for_drain();
        for (k = 0; k < 8; k++)
            send_item(make_item(CMD_DATE, {$urandom, $urandom}));
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_values();
        test_ignored_commands();
        test_random_stream(0, 0, ITEMS_PER_PHASE);
        test_random_stream(80, 0, ITEMS_PER_PHASE);
        test_pause_until_drained();
        test_random_stream(0, 80, ITEMS_PER_PHASE);
        test_random_stream(32, 32, ITEMS_PER_PHASE);

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/csve_pkg.sv
hdl/csve_front.sv
hdl/csve_queue.sv
hdl/csve_back.sv
hdl/compact_scalar_value_encoder.sv
tb/compact_scalar_value_encoder_tb.sv
